FILE: rtl/ips_pkg.sv
// Shared types, constants and the control program of the incremental PID step block.
package ips_pkg;

	localparam int DATA_W = 32;
	localparam int DT_W   = 24;
	localparam int WIDE_W = 66;
	localparam int STEP_W = 5;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] target;
		logic signed [DATA_W-1:0] measured;
		logic [DT_W-1:0]          step_time;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     clamped;
		logic                     bad_step;
	} out_word_t;

	typedef enum logic [2:0] {
		CFG_GAIN_PROP   = 3'd0,
		CFG_GAIN_INTEG  = 3'd1,
		CFG_GAIN_DERIV  = 3'd2,
		CFG_OUT_FLOOR   = 3'd3,
		CFG_OUT_CEILING = 3'd4
	} cfg_reg_t;

	localparam int CFG_IDX_W = $bits(cfg_reg_t);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_ERR,
		OP_DIFF,
		OP_MUL,
		OP_FIX,
		OP_DIVGO,
		OP_DIVFIX,
		OP_ZDD,
		OP_SUM,
		OP_DRIVE,
		OP_OUT,
		OP_CLR
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_GOTO,
		C_WAIT_IN,
		C_IF_CLR,
		C_IF_DTZ,
		C_WAIT_DIV,
		C_WAIT_OUT
	} cond_t;

	typedef enum logic [1:0] {
		MS_P,
		MS_I1,
		MS_I2,
		MS_D
	} mul_sel_t;

	typedef enum logic [1:0] {
		FD_DP,
		FD_TMP,
		FD_DI
	} fix_dst_t;

	typedef struct packed {
		op_t      op;
		mul_sel_t msel;
		fix_dst_t fdst;
		cond_t    cond;
		step_t    target;
	} ctrl_word_t;

	typedef struct packed {
		logic is_clear;
		logic dt_zero;
		logic div_busy;
		logic out_block;
	} dp_status_t;

	localparam step_t ST_FETCH   = 5'd0;
	localparam step_t ST_ERR     = 5'd1;
	localparam step_t ST_DIFF    = 5'd2;
	localparam step_t ST_MULP    = 5'd3;
	localparam step_t ST_FIXP    = 5'd4;
	localparam step_t ST_MULI1   = 5'd5;
	localparam step_t ST_FIXI1   = 5'd6;
	localparam step_t ST_MULI2   = 5'd7;
	localparam step_t ST_FIXI2   = 5'd8;
	localparam step_t ST_MULD    = 5'd9;
	localparam step_t ST_FIXD    = 5'd10;
	localparam step_t ST_DIVGO   = 5'd11;
	localparam step_t ST_DIVWAIT = 5'd12;
	localparam step_t ST_DIVFIX  = 5'd13;
	localparam step_t ST_ZDD     = 5'd14;
	localparam step_t ST_SUM     = 5'd15;
	localparam step_t ST_DRIVE   = 5'd16;
	localparam step_t ST_OUT     = 5'd17;
	localparam step_t ST_CLR     = 5'd18;

	// microcode ROM
	function automatic ctrl_word_t prog_word(input step_t s);
		ctrl_word_t w;
		w = '{op: OP_NOP, msel: MS_P, fdst: FD_DP, cond: C_NEXT, target: ST_FETCH};
		unique case (s)
			ST_FETCH: begin
				w.op = OP_LOAD;
				w.cond = C_WAIT_IN;
			end
			ST_ERR: begin
				w.op = OP_ERR;
				w.cond = C_IF_CLR;
				w.target = ST_CLR;
			end
			ST_DIFF:  w.op = OP_DIFF;
			ST_MULP: begin
				w.op = OP_MUL;
				w.msel = MS_P;
			end
			ST_FIXP: begin
				w.op = OP_FIX;
				w.fdst = FD_DP;
			end
			ST_MULI1: begin
				w.op = OP_MUL;
				w.msel = MS_I1;
			end
			ST_FIXI1: begin
				w.op = OP_FIX;
				w.fdst = FD_TMP;
			end
			ST_MULI2: begin
				w.op = OP_MUL;
				w.msel = MS_I2;
			end
			ST_FIXI2: begin
				w.op = OP_FIX;
				w.fdst = FD_DI;
			end
			ST_MULD: begin
				w.op = OP_MUL;
				w.msel = MS_D;
				w.cond = C_IF_DTZ;
				w.target = ST_ZDD;
			end
			ST_FIXD: begin
				w.op = OP_FIX;
				w.fdst = FD_TMP;
			end
			ST_DIVGO: w.op = OP_DIVGO;
			ST_DIVWAIT: w.cond = C_WAIT_DIV;
			ST_DIVFIX: begin
				w.op = OP_DIVFIX;
				w.cond = C_GOTO;
				w.target = ST_SUM;
			end
			ST_ZDD:   w.op = OP_ZDD;
			ST_SUM:   w.op = OP_SUM;
			ST_DRIVE: w.op = OP_DRIVE;
			ST_OUT: begin
				w.op = OP_OUT;
				w.cond = C_WAIT_OUT;
				w.target = ST_FETCH;
			end
			ST_CLR: begin
				w.op = OP_CLR;
				w.cond = C_GOTO;
				w.target = ST_OUT;
			end
			default: w.cond = C_GOTO;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/ips_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module ips_seq
	import ips_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  dp_status_t status,
	output ctrl_word_t ctrl
);

	step_t step_q;
	step_t step_d;
	step_t step_inc;

	assign ctrl     = prog_word(step_q);
	assign step_inc = step_q + step_t'(1);

	always_comb begin
		unique case (ctrl.cond)
			C_NEXT:     step_d = step_inc;
			C_GOTO:     step_d = ctrl.target;
			C_WAIT_IN:  step_d = item_valid ? step_inc : step_q;
			C_IF_CLR:   step_d = status.is_clear ? ctrl.target : step_inc;
			C_IF_DTZ:   step_d = status.dt_zero ? ctrl.target : step_inc;
			C_WAIT_DIV: step_d = status.div_busy ? step_q : step_inc;
			C_WAIT_OUT: step_d = status.out_block ? step_q : ctrl.target;
			default:    step_d = ST_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

FILE: rtl/ips_div.sv
// Unsigned restoring divider, two quotient bits per cycle, dividend scaled by 2^FRAC_BITS.
module ips_div
	import ips_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [DATA_W-1:0]                       dividend,
	input  logic [DT_W-1:0]                         divisor,
	output logic                                    busy,
	output logic [2*((DATA_W+FRAC_BITS+1)/2)-1:0]   quot
);

	localparam int NUM_W = DATA_W + FRAC_BITS;
	localparam int STEPS = (NUM_W + 1) / 2;
	localparam int QW    = 2 * STEPS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [QW-1:0]    num_q;
	logic [DT_W-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DT_W:0] dvs;
	logic [DT_W:0] r1, r1n, r2, r2n;
	logic          ge1, ge2;

	assign dvs = {1'b0, divisor};
	assign r1  = {rem_q, num_q[QW-1]};
	assign ge1 = r1 >= dvs;
	assign r1n = ge1 ? r1 - dvs : r1;
	assign r2  = {r1n[DT_W-1:0], num_q[QW-2]};
	assign ge2 = r2 >= dvs;
	assign r2n = ge2 ? r2 - dvs : r2;

	assign busy = cnt_q != '0;
	assign quot = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// dividend bits shift out the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= QW'({dividend, {FRAC_BITS{1'b0}}});
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[QW-3:0], ge1, ge2};
			rem_q <= r2n[DT_W-1:0];
		end
	end

endmodule

FILE: rtl/ips_dpath.sv
// Datapath: config and state registers, multiplier, divider, saturation, clamp and result register.
module ips_dpath
	import ips_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_word_t           ctrl,
	input  logic                 item_valid,
	input  in_word_t             item,
	input  logic                 result_stall,
	output logic                 result_valid,
	output out_word_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_data,
	output dp_status_t           status
);

	localparam int QW = 2 * ((DATA_W + FRAC_BITS + 1) / 2);

	localparam logic signed [WIDE_W-1:0] SAT_HI = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] SAT_LO = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] HALF_ONE = DATA_W'(1) << (FRAC_BITS - 1);

	function automatic logic signed [WIDE_W-1:0] wide(input logic signed [DATA_W-1:0] a);
		return {{(WIDE_W-DATA_W){a[DATA_W-1]}}, a};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[DATA_W-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

	// configuration
	logic signed [DATA_W-1:0] gp_q, gi_q, gd_q, floor_q, ceil_q;
	// controller state
	logic signed [DATA_W-1:0] e1_q, e2_q, ld_q;
	logic                     clip_q, bad_q;
	// scratch
	in_word_t                 in_q;
	logic signed [DATA_W-1:0] err_q, d1_q, d2_q, dp_q, di_q, dd_q, tmp_q, sum_q;
	logic signed [WIDE_W-1:0] prod_q;
	out_word_t                out_q;
	logic                     out_valid_q;

	logic signed [DATA_W:0]   mul_a, mul_b;
	logic signed [WIDE_W-1:0] prod_full;
	logic signed [DATA_W-1:0] fix_val;
	logic [DATA_W-1:0]        tmp_u, tmp_mag;
	logic [QW-1:0]            quot;
	logic signed [WIDE_W-1:0] quot_s;
	logic signed [DATA_W-1:0] y_sum, y_next;
	logic                     clip_next;
	logic                     div_start, div_busy;
	logic                     out_load;

	always_comb begin
		unique case (ctrl.msel)
			MS_P: begin
				mul_a = {gp_q[DATA_W-1], gp_q};
				mul_b = {d1_q[DATA_W-1], d1_q};
			end
			MS_I1: begin
				mul_a = {gi_q[DATA_W-1], gi_q};
				mul_b = {err_q[DATA_W-1], err_q};
			end
			MS_I2: begin
				mul_a = {tmp_q[DATA_W-1], tmp_q};
				mul_b = {{(DATA_W+1-DT_W){1'b0}}, in_q.step_time};
			end
			MS_D: begin
				mul_a = {gd_q[DATA_W-1], gd_q};
				mul_b = {d2_q[DATA_W-1], d2_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_full = mul_a * mul_b;
	// arithmetic shift floors toward minus infinity
	assign fix_val   = sat32(prod_q >>> FRAC_BITS);

	assign tmp_u     = tmp_q;
	assign tmp_mag   = tmp_u[DATA_W-1] ? (~tmp_u + DATA_W'(1)) : tmp_u;
	assign div_start = ctrl.op == OP_DIVGO;
	assign quot_s    = $signed(WIDE_W'(quot));

	ips_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tmp_mag),
		.divisor  (in_q.step_time),
		.busy     (div_busy),
		.quot     (quot)
	);

	// floor check first: with floor above ceiling, a sum below the floor gets the floor, any other the ceiling
	always_comb begin
		y_sum = sat32(wide(ld_q) + wide(sum_q));
		priority if (y_sum < floor_q) begin
			y_next = floor_q;
			clip_next = 1'b1;
		end else if (y_sum > ceil_q) begin
			y_next = ceil_q;
			clip_next = 1'b1;
		end else begin
			y_next = y_sum;
			clip_next = 1'b0;
		end
	end

	assign out_load = (ctrl.op == OP_OUT) && (!out_valid_q || !result_stall);

	assign status.is_clear  = in_q.cmd;
	assign status.dt_zero   = in_q.step_time == '0;
	assign status.div_busy  = div_busy;
	assign status.out_block = out_valid_q && result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q        <= '0;
			gi_q        <= '0;
			gd_q        <= '0;
			floor_q     <= -HALF_ONE;
			ceil_q      <= HALF_ONE;
			e1_q        <= '0;
			e2_q        <= '0;
			ld_q        <= '0;
			clip_q      <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_idx))
					CFG_GAIN_PROP:   gp_q <= cfg_data;
					CFG_GAIN_INTEG:  gi_q <= cfg_data;
					CFG_GAIN_DERIV:  gd_q <= cfg_data;
					CFG_OUT_FLOOR:   floor_q <= cfg_data;
					CFG_OUT_CEILING: ceil_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (ctrl.op)
				OP_ERR: bad_q <= 1'b0;
				OP_ZDD: bad_q <= 1'b1;
				OP_DRIVE: begin
					e2_q   <= e1_q;
					e1_q   <= err_q;
					ld_q   <= y_next;
					clip_q <= clip_next;
				end
				OP_CLR: begin
					e1_q   <= '0;
					e2_q   <= '0;
					ld_q   <= '0;
					clip_q <= 1'b0;
					bad_q  <= 1'b0;
				end
				default: ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= '{drive: ld_q, clamped: clip_q, bad_step: bad_q};
		end
		unique case (ctrl.op)
			OP_LOAD: begin
				if (item_valid) begin
					in_q <= item;
				end
			end
			OP_ERR: err_q <= sat32(wide(in_q.target) - wide(in_q.measured));
			OP_DIFF: begin
				d1_q <= sat32(wide(err_q) - wide(e1_q));
				d2_q <= sat32(wide(err_q) - (wide(e1_q) <<< 1) + wide(e2_q));
			end
			OP_MUL: prod_q <= prod_full;
			OP_FIX: begin
				unique case (ctrl.fdst)
					FD_DP:   dp_q <= fix_val;
					FD_TMP:  tmp_q <= fix_val;
					FD_DI:   di_q <= fix_val;
					default: ;
				endcase
			end
			// quotient magnitude truncated, sign restored from the dividend
			OP_DIVFIX: dd_q <= sat32(tmp_q[DATA_W-1] ? -quot_s : quot_s);
			OP_ZDD:    dd_q <= '0;
			OP_SUM:    sum_q <= sat32(wide(dp_q) + wide(di_q) + wide(dd_q));
			default: ;
		endcase
	end

endmodule

FILE: rtl/incremental_pid_step.sv
// Incremental (velocity-form) PID step in signed fixed point with FRAC_BITS fraction bits.
// A word with cmd 0 forms error = target - measured, adds the proportional, integral and
// derivative increments to the last output and clamps the sum to [out_floor, out_ceiling];
// cmd 1 zeroes the stored errors and output and returns zero. Every word gives exactly one
// result word. A microcoded sequencer walks a short program over one shared multiplier and a
// divider, so one word is worked on at a time. The derivative divide retires two quotient
// bits per cycle; a zero step_time skips the divide, and a clear word skips the multiplies
// and the divide. A registered result stage lets the next word in while the last result
// waits; a result still waiting when the next word is done holds the sequencer on its
// output step. Configuration registers are written through cfg_we/cfg_idx/cfg_data; the user
// must write them only while the block is idle, as the block itself does not enforce it.
module incremental_pid_step
	import ips_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  in_word_t             item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_word_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_data
);

	ctrl_word_t ctrl;
	dp_status_t status;

	assign item_stall = ctrl.op != OP_LOAD;

	ips_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.status     (status),
		.ctrl       (ctrl)
	);

	ips_dpath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.item_valid   (item_valid),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.status       (status)
	);

endmodule

FILE: rtl/ips_chk.sv
// Port-level checker for the incremental PID step block, bound to the top level.
module ips_chk
	import ips_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_word_t result
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	// one word in flight: the input closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second word accepted while one is in work");

	// no result can appear the cycle right after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared too early");

endmodule

bind incremental_pid_step ips_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
